[hw/rtl/gec_pkg.sv]
// Shared types and constants for the GPIO edge capture and debounce block.
`timescale 1ns / 1ps

package gec_pkg;

    // Field widths
    localparam int PIN_W  = 4;
    localparam int MASK_W = 16;
    localparam int TIME_W = 32;
    localparam int DB_W   = 30;
    localparam int CNT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Pins that the 16-bit mask can address
    localparam int MAX_PINS     = 16;
    localparam int NUM_PINS_DEF = 16;

    // Event counter saturation value
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Request kinds
    typedef enum logic {
        OP_IRQ   = 1'b0,
        OP_REARM = 1'b1
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIN_ENABLE     = 2'd0,
        REG_DEBOUNCE_TIME  = 2'd1,
        REG_EVENT_CAPACITY = 2'd2
    } t_reg_idx;

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_BUSY = 1'b1
    } t_bk_state;

    // Classified request handed from front to back
    typedef struct packed {
        t_op                op;
        logic [PIN_W-1:0]   pin;
        logic [MASK_W-1:0]  mask;
        logic [MASK_W-1:0]  levels;
        logic [TIME_W-1:0]  now;
    } t_req;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // One result
    typedef struct packed {
        logic [PIN_W-1:0]  pin;
        logic [TIME_W-1:0] period;
        logic              edge_level;
        logic              recorded;
        logic              queue_push;
        logic              queue_level;
        logic              last;
    } t_res;

endpackage

[hw/rtl/gec_front.sv]
// Front end: accepts requests, screens out ones that do nothing, builds the queue entry.
`timescale 1ns / 1ps

module gec_front #(
    parameter int NUM_PINS = gec_pkg::NUM_PINS_DEF
) (
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [gec_pkg::PIN_W-1:0]     i_pin,
    input  logic [gec_pkg::MASK_W-1:0]    i_pending_mask,
    input  logic [gec_pkg::MASK_W-1:0]    i_pin_levels,
    input  logic [gec_pkg::TIME_W-1:0]    i_now,
    input  logic [gec_pkg::MASK_W-1:0]    i_pin_enable,
    input  gec_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output gec_pkg::t_req                 o_req
);

    localparam int ACT = (NUM_PINS < gec_pkg::MAX_PINS) ? NUM_PINS : gec_pkg::MAX_PINS;
    localparam logic [31:0] PIN_MASK_W = (32'd1 << ACT) - 32'd1;
    localparam logic [gec_pkg::MASK_W-1:0] PIN_MASK = PIN_MASK_W[gec_pkg::MASK_W-1:0];
    localparam logic [gec_pkg::PIN_W:0] ACT_CNT = (gec_pkg::PIN_W + 1)'(ACT);

    logic                         accept;
    logic [gec_pkg::MASK_W-1:0]   served;
    logic                         keep;

    // Accept whenever the queue has room
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid & ~i_q_status.full;

    // Pins that give a result: pending, enabled and present
    assign served = i_pending_mask & i_pin_enable & PIN_MASK;

    // Drop rearms of absent pins and interrupts that serve no pin
    always_comb begin
        keep = 1'b0;
        unique case (gec_pkg::t_op'(i_op))
            gec_pkg::OP_REARM: keep = ({1'b0, i_pin} < ACT_CNT);
            gec_pkg::OP_IRQ:   keep = (served != '0);
            default:           keep = 1'b0;
        endcase
    end

    assign o_push        = accept & keep;
    assign o_req.op      = gec_pkg::t_op'(i_op);
    assign o_req.pin     = i_pin;
    assign o_req.mask    = served;
    assign o_req.levels  = i_pin_levels;
    assign o_req.now     = i_now;

endmodule

[hw/rtl/gec_queue.sv]
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps

module gec_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gec_pkg::t_req      i_req,
    input  logic               i_pop,
    output gec_pkg::t_req      o_head,
    output gec_pkg::t_q_status o_status
);

    gec_pkg::t_req r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;

    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);
    assign o_head         = r_mem[r_rd];

    // Occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_status.full))
        else $error("request queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (!o_status.empty))
        else $error("request queue underflow");
`endif

endmodule

[hw/rtl/gec_back.sv]
// Back end: per-pin state; served pins go, one per unstalled cycle, to the output reg.
`timescale 1ns / 1ps

module gec_back #(
    parameter int NUM_PINS = gec_pkg::NUM_PINS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gec_pkg::t_req                i_head,
    input  gec_pkg::t_q_status           i_q_status,
    output logic                         o_pop,
    input  logic [gec_pkg::DB_W-1:0]     i_debounce_time,
    input  logic [gec_pkg::CNT_W-1:0]    i_event_capacity,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output gec_pkg::t_res                o_res
);

    localparam int ACT = (NUM_PINS < gec_pkg::MAX_PINS) ? NUM_PINS : gec_pkg::MAX_PINS;
    localparam int AW  = (ACT > 1) ? $clog2(ACT) : 1;

    // Per-pin state
    logic [gec_pkg::TIME_W-1:0] r_edge_time [ACT];
    logic [gec_pkg::CNT_W-1:0]  r_event_count [ACT];
    logic                       r_armed [ACT];
    logic [gec_pkg::TIME_W-1:0] r_db_start [ACT];

    // Current interrupt being walked
    gec_pkg::t_bk_state          r_state;
    gec_pkg::t_bk_state          n_state;
    logic [gec_pkg::MASK_W-1:0]  r_mask;
    logic [gec_pkg::MASK_W-1:0]  r_levels;
    logic [gec_pkg::TIME_W-1:0]  r_now;

    // Output register
    logic                        r_out_valid;
    gec_pkg::t_res               r_res;

    logic                        emit;
    logic                        out_free;
    logic [gec_pkg::MASK_W-1:0]  low_bit;
    logic [gec_pkg::MASK_W-1:0]  rest_mask;
    logic [gec_pkg::PIN_W-1:0]   cur_pin;
    logic [AW-1:0]               cur_idx;
    logic [AW-1:0]               head_idx;
    logic                        level;
    logic                        rec;
    logic [gec_pkg::TIME_W-1:0]  since_arm;
    logic                        db_expired;
    logic                        push;
    logic                        push_level;
    logic                        next_armed;

    assign out_free = ~r_out_valid | ~i_out_stall;

    // Lowest served pin
    assign low_bit   = r_mask & (~r_mask + 1'b1);
    assign rest_mask = r_mask & ~low_bit;

    always_comb begin
        cur_pin = '0;
        for (int i = 0; i < ACT; i++) begin
            if (low_bit[i]) begin
                cur_pin = cur_pin | gec_pkg::PIN_W'(i);
            end
        end
    end

    assign cur_idx  = cur_pin[AW-1:0];
    assign head_idx = i_head.pin[AW-1:0];

    // Result fields for the current pin
    assign level      = r_levels[cur_pin];
    assign rec        = (r_event_count[cur_idx] < i_event_capacity);
    assign since_arm  = r_now - r_db_start[cur_idx];
    assign db_expired = (since_arm[gec_pkg::DB_W-1:0] > i_debounce_time);

    // Debounce stage: new state pushes at once, armed state waits for a late high level
    always_comb begin
        if (!r_armed[cur_idx]) begin
            push       = 1'b1;
            push_level = level;
            next_armed = 1'b1;
        end else if (db_expired && level) begin
            push       = 1'b1;
            push_level = 1'b1;
            next_armed = 1'b0;
        end else begin
            push       = 1'b0;
            push_level = 1'b0;
            next_armed = 1'b1;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gec_pkg::BK_IDLE: begin
                if (!i_q_status.empty && i_head.op == gec_pkg::OP_IRQ) begin
                    n_state = gec_pkg::BK_BUSY;
                end
            end
            gec_pkg::BK_BUSY: begin
                if (out_free && rest_mask == '0) begin
                    n_state = gec_pkg::BK_IDLE;
                end
            end
            default: n_state = gec_pkg::BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop = 1'b0;
        emit  = 1'b0;
        unique case (r_state)
            gec_pkg::BK_IDLE: o_pop = ~i_q_status.empty;
            gec_pkg::BK_BUSY: emit  = out_free;
            default: begin
                o_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gec_pkg::BK_IDLE;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_head.op == gec_pkg::OP_IRQ) begin
                r_mask <= i_head.mask;
            end else if (emit) begin
                r_mask <= rest_mask;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Interrupt payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == gec_pkg::OP_IRQ) begin
            r_levels <= i_head.levels;
            r_now    <= i_head.now;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res.pin         <= cur_pin;
            r_res.period      <= r_now - r_edge_time[cur_idx];
            r_res.edge_level  <= ~level;
            r_res.recorded    <= rec;
            r_res.queue_push  <= push;
            r_res.queue_level <= push_level;
            r_res.last        <= (rest_mask == '0);
        end
    end

    // Per-pin state update: rearm from the queue head, or the pin being served
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ACT; i++) begin
                r_edge_time[i]   <= '0;
                r_event_count[i] <= '0;
                r_armed[i]       <= 1'b0;
                r_db_start[i]    <= '0;
            end
        end else if (o_pop && i_head.op == gec_pkg::OP_REARM) begin
            r_event_count[head_idx] <= '0;
            r_edge_time[head_idx]   <= i_head.now;
        end else if (emit) begin
            r_edge_time[cur_idx] <= r_now;
            if (rec && r_event_count[cur_idx] != gec_pkg::CNT_MAX) begin
                r_event_count[cur_idx] <= r_event_count[cur_idx] + 1'b1;
            end
            r_armed[cur_idx] <= next_armed;
            if (!r_armed[cur_idx]) begin
                r_db_start[cur_idx] <= r_now;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

`ifndef ASSERT_OFF
    a_busy_has_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gec_pkg::BK_BUSY) |-> (r_mask != '0))
        else $error("walking an interrupt with no pins left");
    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && rest_mask == '0) |=> (r_state == gec_pkg::BK_IDLE && o_out_valid && o_res.last))
        else $error("final result did not end the walk");
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == gec_pkg::BK_IDLE && !emit))
        else $error("queue popped while a walk is in progress");
`endif

endmodule

[hw/rtl/gpio_edge_capture_debounce.sv]
// Top level: configuration registers, front end, request queue and back end.
// Flow: with the back end idle, an accepted interrupt request is written into the queue,
// then loaded by the sequencer, and each result is then put in the output register; a
// rearm updates the pin state when the idle back end pops it from the queue.
// Throughput: the back-end walker gives one result per cycle while the output is not
// stalled, after a pop of the request. The two-entry queue decouples input.
// Reset (synchronous, active low) clears registers, queue, and all per-pin state.
`timescale 1ns / 1ps

module gpio_edge_capture_debounce #(
    parameter int NUM_PINS = gec_pkg::NUM_PINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input requests
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic [gec_pkg::PIN_W-1:0]         i_pin,
    input  logic [gec_pkg::MASK_W-1:0]        i_pending_mask,
    input  logic [gec_pkg::MASK_W-1:0]        i_pin_levels,
    input  logic [gec_pkg::TIME_W-1:0]        i_now,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gec_pkg::PIN_W-1:0]         o_out_pin,
    output logic [gec_pkg::TIME_W-1:0]        o_period,
    output logic                              o_edge_level,
    output logic                              o_recorded,
    output logic                              o_queue_push,
    output logic                              o_queue_level,
    output logic                              o_last,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gec_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gec_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [gec_pkg::MASK_W-1:0] r_pin_enable;
    logic [gec_pkg::DB_W-1:0]   r_debounce_time;
    logic [gec_pkg::CNT_W-1:0]  r_event_capacity;

    logic               q_push;
    logic               q_pop;
    gec_pkg::t_req      front_req;
    gec_pkg::t_req      q_head;
    gec_pkg::t_q_status q_status;
    gec_pkg::t_res      res;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_enable     <= '0;
            r_debounce_time  <= '0;
            r_event_capacity <= '0;
        end else if (i_cfg_valid) begin
            unique case (gec_pkg::t_reg_idx'(i_cfg_index))
                gec_pkg::REG_PIN_ENABLE:
                    r_pin_enable <= i_cfg_data[gec_pkg::MASK_W-1:0];
                gec_pkg::REG_DEBOUNCE_TIME:
                    r_debounce_time <= i_cfg_data[gec_pkg::DB_W-1:0];
                gec_pkg::REG_EVENT_CAPACITY:
                    r_event_capacity <= i_cfg_data[gec_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    gec_front #(
        .NUM_PINS (NUM_PINS)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_pin          (i_pin),
        .i_pending_mask (i_pending_mask),
        .i_pin_levels   (i_pin_levels),
        .i_now          (i_now),
        .i_pin_enable   (r_pin_enable),
        .i_q_status     (q_status),
        .o_push         (q_push),
        .o_req          (front_req)
    );

    gec_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_req    (front_req),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    gec_back #(
        .NUM_PINS (NUM_PINS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (q_head),
        .i_q_status       (q_status),
        .o_pop            (q_pop),
        .i_debounce_time  (r_debounce_time),
        .i_event_capacity (r_event_capacity),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_res            (res)
    );

    assign o_out_pin     = res.pin;
    assign o_period      = res.period;
    assign o_edge_level  = res.edge_level;
    assign o_recorded    = res.recorded;
    assign o_queue_push  = res.queue_push;
    assign o_queue_level = res.queue_level;
    assign o_last        = res.last;

endmodule

[verif/gpio_edge_capture_debounce_tb.sv]
// Self-checking testbench for the GPIO edge capture and debounce block.
`timescale 1ns / 1ps

module gpio_edge_capture_debounce_tb;
    import gec_pkg::*;

    localparam int PINS            = NUM_PINS_DEF;
    localparam int RAND_PHASES     = 5;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int DRAIN_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // index with no register behind it

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_op = OP_IRQ;
    logic [PIN_W-1:0]      i_pin = '0;
    logic [MASK_W-1:0]     i_pending_mask = '0;
    logic [MASK_W-1:0]     i_pin_levels = '0;
    logic [TIME_W-1:0]     i_now = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PIN_W-1:0]      o_out_pin;
    logic [TIME_W-1:0]     o_period;
    logic                  o_edge_level;
    logic                  o_recorded;
    logic                  o_queue_push;
    logic                  o_queue_level;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Pending requests and expected edge results
    t_req req_q[$];
    t_res edge_exp_q[$];

    // Predictor copy of the registers and per-pin state
    logic [MASK_W-1:0] en_mask = '0;
    logic [DB_W-1:0]   db_time = '0;
    logic [CNT_W-1:0]  cap = '0;
    logic [TIME_W-1:0] edge_tm[PINS];
    logic [CNT_W-1:0]  ev_cnt[PINS];
    logic              armed[PINS];
    logic [TIME_W-1:0] db_start[PINS];

    // Run control and bookkeeping
    bit          quiet = 1'b0;
    int          errors = 0;
    int          n_items = 0;
    int          n_rearm = 0;
    int          n_results = 0;
    int          n_cfg = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    logic [31:0] now_us = '0;
    t_req        next_req;
    logic        nxt_valid;

    gpio_edge_capture_debounce dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_pin          (i_pin),
        .i_pending_mask (i_pending_mask),
        .i_pin_levels   (i_pin_levels),
        .i_now          (i_now),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_pin      (o_out_pin),
        .o_period       (o_period),
        .o_edge_level   (o_edge_level),
        .o_recorded     (o_recorded),
        .o_queue_push   (o_queue_push),
        .o_queue_level  (o_queue_level),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        for (int p = 0; p < PINS; p++) begin
            edge_tm[p]  = '0;
            ev_cnt[p]   = '0;
            armed[p]    = 1'b0;
            db_start[p] = '0;
        end
    end

    // Register write as seen by the block
    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        n_cfg++;
        case (idx)
            REG_PIN_ENABLE:     en_mask = data[MASK_W-1:0];
            REG_DEBOUNCE_TIME:  db_time = data[DB_W-1:0];
            REG_EVENT_CAPACITY: cap     = data[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Expected edge results of one request; updates the per-pin state
    function automatic void predict_edges(t_req r);
        logic [DB_W-1:0] elapsed;
        logic            lvl;
        logic            rec;
        t_res            res;
        int              p;
        int              n;
        n_items++;
        n = 0;
        if (r.op == OP_REARM) begin
            n_rearm++;
            if (int'(r.pin) < PINS) begin
                ev_cnt[r.pin]  = '0;
                edge_tm[r.pin] = r.now;
            end
        end else begin
            for (p = 0; p < PINS; p++) begin
                if (r.mask[p] && en_mask[p]) begin
                    lvl = r.levels[p];
                    rec = (ev_cnt[p] < cap);
                    if (rec && ev_cnt[p] != CNT_MAX)
                        ev_cnt[p] = ev_cnt[p] + 1'b1;
                    res.pin         = PIN_W'(p);
                    res.period      = r.now - edge_tm[p];
                    res.edge_level  = ~lvl;
                    res.recorded    = rec;
                    res.queue_push  = 1'b0;
                    res.queue_level = 1'b0;
                    res.last        = 1'b0;
                    edge_tm[p] = r.now;
                    // debounce: new state pushes at once, armed state waits out the interval for a high level
                    if (!armed[p]) begin
                        db_start[p]     = r.now;
                        res.queue_push  = 1'b1;
                        res.queue_level = lvl;
                        armed[p]        = 1'b1;
                    end else begin
                        elapsed = DB_W'(r.now - db_start[p]);
                        if (elapsed > db_time && lvl) begin
                            res.queue_push  = 1'b1;
                            res.queue_level = 1'b1;
                            armed[p]        = 1'b0;
                        end
                    end
                    edge_exp_q.push_back(res);
                    n++;
                end
            end
            if (n > 0) begin
                res = edge_exp_q.pop_back();
                res.last = 1'b1;
                edge_exp_q.push_back(res);
            end
        end
    endfunction

    function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Driver: feeds queued requests, with random gaps unless quiet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_q.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 18) - 1;
            end else if (req_q.size() > 0) begin
                next_req = req_q.pop_front();
                i_op           <= next_req.op;
                i_pin          <= next_req.pin;
                i_pending_mask <= next_req.mask;
                i_pin_levels   <= next_req.levels;
                i_now          <= next_req.now;
                nxt_valid = 1'b1;
            end
            i_in_valid <= nxt_valid;
        end
    end

    // Monitor: checks results, predicts accepted requests, drives output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (edge_exp_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual pin %0d period %0h",
                             $time, o_out_pin, o_period);
                end else begin
                    t_res e;
                    e = edge_exp_q.pop_front();
                    cmp_field("out_pin",     32'(e.pin),         32'(o_out_pin));
                    cmp_field("period",      e.period,           o_period);
                    cmp_field("edge_level",  32'(e.edge_level),  32'(o_edge_level));
                    cmp_field("recorded",    32'(e.recorded),    32'(o_recorded));
                    cmp_field("queue_push",  32'(e.queue_push),  32'(o_queue_push));
                    cmp_field("queue_level", 32'(e.queue_level), 32'(o_queue_level));
                    cmp_field("last",        32'(e.last),        32'(o_last));
                end
            end
            if (i_in_valid && !o_in_stall)
                predict_edges(t_req'({i_op, i_pin, i_pending_mask, i_pin_levels, i_now}));
            if (i_cfg_valid && o_cfg_ready)
                apply_cfg(i_cfg_index, i_cfg_data);
            // stall bursts
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: no handshake of any kind for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every request is in and every result is out, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        while (req_q.size() != 0 || i_in_valid || edge_exp_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_req(t_op op, logic [PIN_W-1:0] pin, logic [MASK_W-1:0] mask,
                                    logic [MASK_W-1:0] levels, logic [TIME_W-1:0] now);
        t_req r;
        r.op     = op;
        r.pin    = pin;
        r.mask   = mask;
        r.levels = levels;
        r.now    = now;
        req_q.push_back(r);
    endfunction

    // Random requests on a mostly advancing clock, with occasional jumps
    task automatic fill_random(int n, bit no_idle);
        t_req r;
        int   k;
        @(negedge i_clk);
        quiet = no_idle;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0)
                now_us = $urandom;
            else
                now_us = now_us + $urandom_range(0, 400);
            r.now    = now_us;
            r.pin    = PIN_W'($urandom);
            r.levels = MASK_W'($urandom);
            if ($urandom_range(0, 99) < 15) begin
                r.op   = OP_REARM;
                r.mask = MASK_W'($urandom);
            end else begin
                r.op = OP_IRQ;
                case ($urandom_range(0, 3))
                    0:       r.mask = MASK_W'(1) << $urandom_range(0, 15);
                    1:       r.mask = MASK_W'($urandom);
                    2:       r.mask = '1;
                    default: r.mask = MASK_W'($urandom & $urandom);
                endcase
            end
            req_q.push_back(r);
        end
    endtask

    // Test sequence
    initial begin
        logic [MASK_W-1:0] en;
        logic [31:0]       db;
        logic [CNT_W-1:0]  cp;
        int                ph;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: nothing enabled, so no results
        @(negedge i_clk);
        add_req(OP_IRQ, 4'h0, 16'hFFFF, 16'hFFFF, 32'd5);
        wait_idle();

        // all pins on, no debounce interval, small capacity
        write_reg(REG_PIN_ENABLE, 32'h0000_FFFF);
        write_reg(REG_DEBOUNCE_TIME, 32'd0);
        write_reg(REG_EVENT_CAPACITY, 32'd3);
        @(negedge i_clk);
        add_req(OP_IRQ,   4'h0, 16'hFFFF, 16'h0000, 32'd0);
        add_req(OP_IRQ,   4'h0, 16'hFFFF, 16'hFFFF, 32'd1);
        add_req(OP_IRQ,   4'h0, 16'h0001, 16'h0000, 32'd2);
        add_req(OP_IRQ,   4'h0, 16'h0001, 16'h0001, 32'd2);    // zero elapsed, no push
        add_req(OP_IRQ,   4'hF, 16'h0001, 16'h0001, 32'd3);    // over capacity
        add_req(OP_REARM, 4'h0, 16'h0000, 16'h0000, 32'd100);
        add_req(OP_IRQ,   4'h0, 16'h0001, 16'h0001, 32'd50);   // period wraps back
        add_req(OP_IRQ,   4'h0, 16'h8000, 16'h0000, 32'hFFFF_FFFF);
        add_req(OP_REARM, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        add_req(OP_IRQ,   4'h0, 16'h8000, 16'h8000, 32'h0000_0010);
        add_req(OP_IRQ,   4'h0, 16'h0000, 16'hFFFF, 32'd150);  // nothing pending
        add_req(OP_IRQ,   4'h0, 16'hAAAA, 16'h5555, 32'd200);
        add_req(OP_IRQ,   4'h0, 16'h5555, 16'hAAAA, 32'd300);
        wait_idle();

        // two pins, widest debounce interval, zero capacity; upper data bits must drop
        write_reg(REG_PIN_ENABLE, 32'hFFFF_8001);
        write_reg(REG_DEBOUNCE_TIME, 32'hFFFF_FFFF);
        write_reg(REG_EVENT_CAPACITY, 32'hFFFF_0000);
        write_reg(REG_SPARE, 32'h0000_0005);
        @(negedge i_clk);
        add_req(OP_IRQ,   4'h0, 16'hFFFF, 16'hFFFF, 32'h4000_0400);
        add_req(OP_IRQ,   4'h0, 16'hFFFF, 16'hFFFF, 32'h8000_0400);  // elapsed wraps past its 30-bit width
        add_req(OP_IRQ,   4'h0, 16'hFFFF, 16'hFFFF, 32'hC000_03FF);  // elapsed wraps again, still below the interval
        add_req(OP_REARM, 4'h7, 16'h0000, 16'h0000, 32'hDEAD_BEEF);
        add_req(OP_IRQ,   4'h0, 16'h0080, 16'h0080, 32'hDEAD_BEF0);  // pending but disabled
        wait_idle();

        now_us = $urandom;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    en = '1;
                    db = $urandom_range(0, 300);
                    cp = CNT_W'($urandom_range(1, 6));
                end
                1: begin
                    en = MASK_W'($urandom);
                    db = 0;
                    cp = '1;
                end
                2: begin
                    en = MASK_W'($urandom);
                    db = $urandom_range(0, 1000);
                    cp = '0;
                end
                3: begin
                    en = MASK_W'($urandom | $urandom);
                    db = $urandom;
                    cp = CNT_W'($urandom_range(0, 40));
                end
                default: begin
                    en = '1;
                    db = $urandom_range(0, 200);
                    cp = CNT_W'($urandom_range(0, 20));
                end
            endcase
            write_reg(REG_PIN_ENABLE, {16'($urandom), en});
            write_reg(REG_DEBOUNCE_TIME, {2'($urandom), db[DB_W-1:0]});
            write_reg(REG_EVENT_CAPACITY, {16'($urandom), cp});
            if (ph == 2)
                write_reg(REG_SPARE, $urandom);
            fill_random(ITEMS_PER_PHASE, ph == RAND_PHASES - 1);
            wait_idle();
        end

        $display("Covered %0d requests (%0d rearms), %0d edge results, %0d register writes",
                 n_items, n_rearm, n_results, n_cfg);
        $display("across disabled, saturated, wrapped-time and debounce-interval settings");
        if (errors == 0 && edge_exp_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
